@@ rtl/wfu_pkg.sv @@
// Shared types and constants of the WebSocket frame unmasker.
`default_nettype none

package wfu_pkg;

    localparam int BYTE_W      = 8;
    localparam int OPC_W       = 4;
    localparam int LEN_W       = 7;
    localparam int KEY_BYTES   = 4;
    localparam int KEY_IDX_W   = 2;
    localparam int USER_W      = 7;
    localparam int QUEUE_DEPTH = 4;

    // Length codes at or above this value announce an extended length field.
    localparam logic [LEN_W-1:0] LONG_LEN_MIN = 7'd126;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_KEY0 = 3'd2,
        PH_KEY1 = 3'd3,
        PH_KEY2 = 3'd4,
        PH_KEY3 = 3'd5,
        PH_DATA = 3'd6
    } phase_t;

    // One classified request on its way from the parser to the output stage.
    typedef struct packed {
        logic [BYTE_W-1:0] raw_byte;
        logic [BYTE_W-1:0] key_byte;
        logic              fin;
        logic [OPC_W-1:0]  opcode;
        logic              no_payload;
        logic              last;
        logic              long_code;
    } entry_t;

endpackage : wfu_pkg

`default_nettype wire

@@ rtl/wfu_front.sv @@
// Header parser: classifies frame bytes and builds payload requests.
`default_nettype none

module wfu_front
    import wfu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] in_byte,
    output logic                   push,
    output entry_t                 entry
);

    phase_t                phase_reg,  phase_next;
    logic [BYTE_W-1:0]     key_reg [KEY_BYTES];
    logic [LEN_W-1:0]      left_reg,   left_next;
    logic [KEY_IDX_W-1:0]  kidx_reg,   kidx_next;
    logic                  masked_reg, masked_next;
    logic                  fin_reg,    fin_next;
    logic [OPC_W-1:0]      opcode_reg, opcode_next;
    logic                  long_reg,   long_next;
    logic [LEN_W-1:0]      left_dec;
    logic                  key_wr;
    logic [KEY_IDX_W-1:0]  key_wr_idx;

    assign left_dec = LEN_W'(left_reg - 7'd1);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HDR2:
            begin
                if (in_byte[BYTE_W-1])
                    phase_next = PH_KEY0;
                else if (in_byte[LEN_W-1:0] == '0)
                    phase_next = PH_HDR1;
                else
                    phase_next = PH_DATA;
            end
            PH_KEY0: phase_next = PH_KEY1;
            PH_KEY1: phase_next = PH_KEY2;
            PH_KEY2: phase_next = PH_KEY3;
            PH_KEY3: phase_next = (left_reg == '0) ? PH_HDR1 : PH_DATA;
            PH_DATA: phase_next = (left_dec == '0) ? PH_HDR1 : PH_DATA;
            default: phase_next = PH_HDR2;
        endcase
    end

    // Header fields, key capture and the request towards the queue.
    always_comb
    begin
        left_next   = left_reg;
        kidx_next   = kidx_reg;
        masked_next = masked_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        long_next   = long_reg;
        key_wr      = 1'b0;
        key_wr_idx  = KEY_IDX_W'(phase_reg - PH_KEY0);
        push        = 1'b0;
        entry       = '{raw_byte: '0, key_byte: '0, fin: fin_reg, opcode: opcode_reg,
                        no_payload: 1'b1, last: 1'b1, long_code: long_reg};
        case (phase_reg)
            PH_HDR2:
            begin
                masked_next = in_byte[BYTE_W-1];
                left_next   = in_byte[LEN_W-1:0];
                long_next   = (in_byte[LEN_W-1:0] >= LONG_LEN_MIN);
                kidx_next   = '0;
                push        = !in_byte[BYTE_W-1] && (in_byte[LEN_W-1:0] == '0);
                entry.long_code = long_next;
            end
            PH_KEY0, PH_KEY1, PH_KEY2:
            begin
                key_wr = 1'b1;
            end
            PH_KEY3:
            begin
                key_wr = 1'b1;
                push   = (left_reg == '0);
            end
            PH_DATA:
            begin
                kidx_next        = KEY_IDX_W'(kidx_reg + 2'd1);
                left_next        = left_dec;
                push             = 1'b1;
                entry.raw_byte   = in_byte;
                entry.key_byte   = masked_reg ? key_reg[kidx_reg] : '0;
                entry.no_payload = 1'b0;
                entry.last       = (left_dec == '0);
            end
            default:
            begin
                // First header byte; the reserved bits are ignored.
                fin_next    = in_byte[BYTE_W-1];
                opcode_next = in_byte[OPC_W-1:0];
            end
        endcase
        push = push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            left_reg   <= '0;
            kidx_reg   <= '0;
            masked_reg <= 1'b0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            long_reg   <= 1'b0;
            for (int i = 0; i < KEY_BYTES; i++)
                key_reg[i] <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            kidx_reg   <= kidx_next;
            masked_reg <= masked_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            long_reg   <= long_next;
            if (key_wr)
                key_reg[key_wr_idx] <= in_byte;
        end
    end

endmodule : wfu_front

`default_nettype wire

@@ rtl/wfu_queue.sv @@
// Small request queue between the parser and the output stage.
`default_nettype none

module wfu_queue
    import wfu_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  entry_t    push_entry,
    input  wire logic pop,
    output entry_t    head,
    output logic      full,
    output logic      empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    entry_t            slot_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg,  count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CntW'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CntW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule : wfu_queue

`default_nettype wire

@@ rtl/wfu_back.sv @@
// Output stage: applies the mask key and holds the result for the sink.
`default_nettype none

module wfu_back
    import wfu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               queue_empty,
    input  entry_t                  head,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [BYTE_W-1:0]       m_axis_tdata,
    output logic                    m_axis_tlast,
    output logic [USER_W-1:0]       m_axis_tuser
);

    logic                 valid_reg;
    logic [BYTE_W-1:0]    data_reg;
    logic                 last_reg;
    logic [USER_W-1:0]    user_reg;

    assign pop = !queue_empty && (!valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_axis_tready)
            valid_reg <= !queue_empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head.raw_byte ^ head.key_byte;
            last_reg <= head.last;
            user_reg <= {head.long_code, head.no_payload, head.opcode, head.fin};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

endmodule : wfu_back

`default_nettype wire

@@ rtl/websocket_frame_unmasker_unit.sv @@
// Top level of the WebSocket frame deframer and unmasker.
// A payload byte accepted on the slave side is written into the request queue, then moved,
// unmasked, into the output register, which holds it on the master side until the sink takes it.
// Throughput: one byte per cycle, sustained as long as the sink takes one result per cycle.
// Header and key bytes give a result only for an empty frame; the queue absorbs sink stalls.
// Reset (rst_n low, asynchronous) returns the parser to the first header byte and empties
// the queue and the output register; the block is ready in the first cycle after reset.
`default_nettype none

module websocket_frame_unmasker_unit
    import wfu_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [7:0] in_byte
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] out_byte
    output logic [BYTE_W-1:0]       m_axis_tdata,
    // last_of_frame
    output logic                    m_axis_tlast,
    // [0] frame_fin, [4:1] frame_opcode, [5] no_payload, [6] long_length_code
    output logic [USER_W-1:0]       m_axis_tuser
);

    logic   accept;
    logic   push;
    entry_t push_entry;
    entry_t head;
    logic   pop;
    logic   full;
    logic   empty;

    // The parser takes a byte whenever the queue has room, so header and key
    // bytes keep flowing even while a finished result waits at the output.
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wfu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .push    (push),
        .entry   (push_entry)
    );

    // The queue decouples the parser from sink back-pressure.
    wfu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    // The output stage unmasks the byte and holds it until the sink takes it.
    wfu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (empty),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule : websocket_frame_unmasker_unit

`default_nettype wire

@@ rtl/wfu_checker.sv @@
// Port-level checker of the frame unmasker, bound to the top level.
`default_nettype none

module wfu_checker
    import wfu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [BYTE_W-1:0] m_axis_tdata,
    input  wire logic              m_axis_tlast,
    input  wire logic [USER_W-1:0] m_axis_tuser
);

    logic              open_reg;
    logic [OPC_W:0]    hdr_reg;

    // Tracks whether a frame has delivered results but not yet its last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            hdr_reg  <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            open_reg <= !m_axis_tlast;
            hdr_reg  <= m_axis_tuser[OPC_W:0];
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[5] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("zero-length result is not a lone zero byte");

    a_same_header: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && open_reg |->
            (m_axis_tuser[OPC_W:0] == hdr_reg) && !m_axis_tuser[5])
        else $error("header fields changed inside a frame");

endmodule : wfu_checker

bind websocket_frame_unmasker_unit wfu_checker u_wfu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
